// ===== sv/vtr_pkg.sv =====
// Shared types, codes and constants for the virtual trackball rotation unit.
package vtr_pkg;

  localparam logic [15:0] RADIUS_RST = 16'd26214;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef logic signed [33:0] opnd_t;
  typedef logic signed [67:0] acc_t;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } drag_req_t;

  typedef struct packed {
    logic signed [31:0] orient_w;
    logic signed [31:0] orient_x;
    logic signed [31:0] orient_y;
    logic signed [31:0] orient_z;
  } orient_t;

  typedef enum logic {OP_DIV, OP_SQRT} unit_op_t;

  typedef struct packed {
    logic        start;
    unit_op_t    op;
    logic [63:0] num;
    logic [32:0] den;
  } unit_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } unit_rsp_t;

  typedef struct packed {
    logic  valid;
    logic  clear;
    logic  neg;
    opnd_t a;
    opnd_t b;
  } mac_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_R2, S_D2, S_ZSPH, S_DHYP, S_ZHYP, S_CROSS, S_NORM,
    S_LEN, S_TDIV, S_TW, S_RV, S_HAM, S_DONE
  } state_t;

endpackage

// ===== sv/vtr_mac.sv =====
// Registered multiplier feeding a signed accumulator.
module vtr_mac import vtr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mac_req_t req,
  output acc_t     acc
);

  acc_t prod;
  logic v1, clr1, neg1;
  opnd_t a_s, b_s;

  assign a_s = req.a;
  assign b_s = req.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req.valid;
    end
    clr1 <= req.clear;
    neg1 <= req.neg;
    prod <= a_s * b_s;
    if (v1) begin
      acc <= (clr1 ? '0 : acc) + (neg1 ? -prod : prod);
    end
  end

endmodule

// ===== sv/vtr_divsqrt.sv =====
// Shared bit-serial unsigned divider and integer square root.
module vtr_divsqrt import vtr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  unit_op_t    op;
  logic [63:0] num_sh;
  logic [32:0] rem;
  logic [32:0] den;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;

  logic [33:0] dv_trial, dv_diff;
  logic        dv_ge;
  logic [34:0] sq_trial, sq_cand, sq_diff;
  logic        sq_ge;

  assign dv_trial = {rem, num_sh[63]};
  assign dv_ge    = dv_trial >= {1'b0, den};
  assign dv_diff  = dv_trial - {1'b0, den};
  assign sq_trial = {rem, num_sh[63:62]};
  assign sq_cand  = {1'b0, quo[31:0], 2'b01};
  assign sq_ge    = sq_trial >= sq_cand;
  assign sq_diff  = sq_trial - sq_cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        op     <= req.op;
        num_sh <= req.num;
        den    <= req.den;
        rem    <= '0;
        quo    <= '0;
        cnt    <= (req.op == OP_DIV) ? 7'd64 : 7'd32;
      end else if (busy) begin
        unique case (op)
          OP_DIV: begin
            rem    <= dv_ge ? dv_diff[32:0] : dv_trial[32:0];
            quo    <= {quo[62:0], dv_ge};
            num_sh <= {num_sh[62:0], 1'b0};
          end
          OP_SQRT: begin
            rem    <= sq_ge ? sq_diff[32:0] : sq_trial[32:0];
            quo    <= {quo[62:0], sq_ge};
            num_sh <= {num_sh[61:0], 2'b00};
          end
          default: ;
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = quo;

endmodule

// ===== sv/virtual_trackball_rotation_unit.sv =====
// Virtual trackball: maps a drag onto the ball and pre-multiplies the rotation.
// Reset requests and equal points go straight to the output; a zero axis ends
// a drag at the norm; else most time goes to the shared divider / root unit.
// Throughput: one request at a time; the next is taken while the last result
// still waits at the output register.
// Reset (rst, synchronous): orientation to identity, radius to 0.8, idle.
module virtual_trackball_rotation_unit import vtr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  drag_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output orient_t   out_data,
  input  logic      cfg_wen,
  input  logic [15:0] cfg_wdata
);

  localparam acc_t RND_HALF = 68'sd536870912;
  localparam acc_t SAT_HI   = 68'sd2147483647;
  localparam acc_t SAT_LO   = -68'sd2147483648;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] T_MAX   = 64'd1073741824;

  // Q.60 sum rounded to Q.30 and saturated
  function automatic logic signed [31:0] rsat(acc_t s);
    acc_t v;
    v = (s + RND_HALF) >>> 30;
    if (v > SAT_HI) return 32'sh7fff_ffff;
    if (v < SAT_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Hamilton product sign of term k in row oi (rq[k] * q[k ^ oi])
  function automatic logic ham_neg(logic [1:0] oi, logic [1:0] kk);
    logic [3:0] m;
    case (oi)
      2'd0:    m = 4'b1110;
      2'd1:    m = 4'b1000;
      2'd2:    m = 4'b0010;
      default: m = 4'b0100;
    endcase
    return m[kk];
  endfunction

  function automatic opnd_t xy_ext(logic signed [15:0] v);
    return {{3{v[15]}}, v, 15'b0};
  endfunction

  state_t state, state_next;

  logic [15:0] radius;
  logic signed [15:0] sx1, sy1, sx2, sy2;
  logic [31:0] r2, d2, dhyp, z1, z2, n, len;
  logic [30:0] t;
  logic signed [31:0] c [3];
  logic signed [31:0] rq [4];
  logic signed [31:0] q [4];
  logic signed [31:0] qn [3];
  logic        pt;
  logic [1:0]  ci;
  logic [2:0]  k;
  logic        wait_unit;

  logic [2:0]  n_terms;
  logic        need_unit, acc_rdy, step_end, sphere;
  mac_req_t    mac_req;
  acc_t        acc;
  unit_req_t   unit_req;
  unit_rsp_t   unit_rsp;
  opnd_t       p1 [3];
  opnd_t       p2 [3];
  opnd_t       dv [3];
  logic [63:0] acc_mag;
  logic        same_pts;
  logic [1:0]  cj, cl;

  vtr_mac u_mac (.clk(clk), .rst(rst), .req(mac_req), .acc(acc));
  vtr_divsqrt u_unit (.clk(clk), .rst(rst), .req(unit_req), .rsp(unit_rsp));

  // mapped points, Q.30
  always_comb begin
    p1[0] = xy_ext(sx1);
    p1[1] = xy_ext(sy1);
    p1[2] = {2'b00, z1};
    p2[0] = xy_ext(sx2);
    p2[1] = xy_ext(sy2);
    p2[2] = {2'b00, z2};
    for (int i = 0; i < 3; i++) begin
      dv[i] = p1[i] - p2[i];
    end
  end

  assign same_pts = (in_data.start_x == in_data.end_x) && (in_data.start_y == in_data.end_y);
  assign sphere   = {acc[31:0], 1'b0} < {1'b0, r2};
  assign acc_mag  = acc[67] ? 64'(-acc) : acc[63:0];
  assign cj       = (ci == 2'd2) ? 2'd0 : ci + 2'd1;
  assign cl       = (ci == 2'd0) ? 2'd2 : ci - 2'd1;
  assign acc_rdy  = (k == n_terms + 3'd1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = (in_data.kind || same_pts) ? S_DONE : S_R2;
      S_R2:    if (step_end) state_next = S_D2;
      S_D2:    if (step_end) state_next = sphere ? S_ZSPH : S_DHYP;
      S_ZSPH:  if (step_end) state_next = pt ? S_CROSS : S_D2;
      S_DHYP:  if (step_end) state_next = S_ZHYP;
      S_ZHYP:  if (step_end) state_next = pt ? S_CROSS : S_D2;
      S_CROSS: if (step_end && ci == 2'd2) state_next = S_NORM;
      S_NORM:  if (step_end) state_next = (unit_rsp.result == '0) ? S_DONE : S_LEN;
      S_LEN:   if (step_end) state_next = S_TDIV;
      S_TDIV:  if (step_end) state_next = S_TW;
      S_TW:    if (step_end) state_next = S_RV;
      S_RV:    if (step_end && ci == 2'd2) state_next = S_HAM;
      S_HAM:   if (step_end && ci == 2'd3) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: MAC terms and unit requests
  always_comb begin
    in_ready  = 1'b0;
    n_terms   = 3'd0;
    need_unit = 1'b0;
    mac_req   = '0;
    unit_req  = '0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_R2: begin
        n_terms   = 3'd1;
        mac_req.a = {18'b0, radius};
        mac_req.b = {18'b0, radius};
      end
      S_D2: begin
        n_terms   = 3'd2;
        mac_req.a = (k == 3'd0) ? 34'(pt ? sx2 : sx1) : 34'(pt ? sy2 : sy1);
        mac_req.b = mac_req.a;
      end
      S_ZSPH: begin
        need_unit    = 1'b1;
        unit_req.op  = OP_SQRT;
        unit_req.num = {2'b00, r2 - d2, 30'b0};
      end
      S_DHYP: begin
        need_unit    = 1'b1;
        unit_req.op  = OP_SQRT;
        unit_req.num = {2'b00, d2, 30'b0};
      end
      S_ZHYP: begin
        need_unit    = (dhyp != '0);
        unit_req.op  = OP_DIV;
        unit_req.num = {2'b00, r2, 30'b0};
        unit_req.den = {dhyp, 1'b0};
      end
      S_CROSS: begin
        n_terms     = 3'd2;
        mac_req.neg = (k == 3'd1);
        mac_req.a   = (k == 3'd0) ? p1[cj] : p1[cl];
        mac_req.b   = (k == 3'd0) ? p2[cl] : p2[cj];
      end
      S_NORM: begin
        n_terms      = 3'd3;
        mac_req.a    = 34'(c[k[1:0]]);
        mac_req.b    = 34'(c[k[1:0]]);
        need_unit    = 1'b1;
        unit_req.op  = OP_SQRT;
        unit_req.num = acc[63:0];
      end
      S_LEN: begin
        n_terms      = 3'd3;
        mac_req.a    = dv[k[1:0]];
        mac_req.b    = dv[k[1:0]];
        need_unit    = 1'b1;
        unit_req.op  = OP_SQRT;
        unit_req.num = acc[63:0];
      end
      S_TDIV: begin
        need_unit    = (radius != '0);
        unit_req.op  = OP_DIV;
        unit_req.num = {17'b0, len, 15'b0};
        unit_req.den = {16'b0, radius, 1'b0};
      end
      S_TW: begin
        n_terms      = 3'd1;
        mac_req.a    = {3'b0, t};
        mac_req.b    = {3'b0, t};
        need_unit    = 1'b1;
        unit_req.op  = OP_SQRT;
        unit_req.num = ONE_Q60 - acc[63:0];
      end
      S_RV: begin
        n_terms      = 3'd1;
        mac_req.a    = 34'(c[ci]);
        mac_req.b    = {3'b0, t};
        need_unit    = 1'b1;
        unit_req.op  = OP_DIV;
        unit_req.num = acc_mag;
        unit_req.den = {1'b0, n};
      end
      S_HAM: begin
        n_terms     = 3'd4;
        mac_req.neg = ham_neg(ci, k[1:0]);
        mac_req.a   = 34'(rq[k[1:0]]);
        mac_req.b   = 34'(q[k[1:0] ^ ci]);
      end
      S_DONE: ;
      default: ;
    endcase
    if (state != S_IDLE && state != S_DONE) begin
      mac_req.valid  = (k < n_terms);
      mac_req.clear  = (k == 3'd0);
      unit_req.start = acc_rdy && need_unit && !wait_unit;
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  step_end = in_valid;
      S_DONE:  step_end = !out_valid || out_ready;
      default: step_end = acc_rdy && (!need_unit || (wait_unit && unit_rsp.done));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      radius    <= RADIUS_RST;
      k         <= '0;
      wait_unit <= 1'b0;
      pt        <= 1'b0;
      ci        <= '0;
      out_valid <= 1'b0;
      q[0]      <= ONE_Q30;
      q[1]      <= '0;
      q[2]      <= '0;
      q[3]      <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) radius <= cfg_wdata;

      if (step_end) k <= '0;
      else if (!acc_rdy) k <= k + 3'd1;

      if (step_end) wait_unit <= 1'b0;
      else if (unit_req.start) wait_unit <= 1'b1;

      // a new result may replace the one taken at this edge
      if (state == S_DONE && step_end) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (step_end) begin
        unique case (state) inside
          S_IDLE: begin
            sx1 <= in_data.start_x;
            sy1 <= in_data.start_y;
            sx2 <= in_data.end_x;
            sy2 <= in_data.end_y;
            pt  <= 1'b0;
            ci  <= '0;
            if (in_data.kind) begin
              q[0] <= ONE_Q30;
              q[1] <= '0;
              q[2] <= '0;
              q[3] <= '0;
            end
          end
          S_R2: r2 <= acc[31:0];
          S_D2: d2 <= acc[31:0];
          S_ZSPH, S_ZHYP: begin
            // hyperbolic branch at the center: z is zero
            if (state == S_ZHYP && dhyp == '0) begin
              if (pt) z2 <= '0;
              else z1 <= '0;
            end else if (pt) begin
              z2 <= unit_rsp.result[31:0];
            end else begin
              z1 <= unit_rsp.result[31:0];
            end
            pt <= 1'b1;
          end
          S_DHYP: dhyp <= unit_rsp.result[31:0];
          S_CROSS: begin
            c[ci] <= acc[63:32];
            ci    <= (ci == 2'd2) ? 2'd0 : ci + 2'd1;
          end
          S_NORM: n <= unit_rsp.result[31:0];
          S_LEN:  len <= unit_rsp.result[31:0];
          S_TDIV: begin
            // zero radius or large drag: t clamps to one
            if (radius == '0 || unit_rsp.result > T_MAX) t <= T_MAX[30:0];
            else t <= unit_rsp.result[30:0];
          end
          S_TW: rq[0] <= unit_rsp.result[31:0];
          S_RV: begin
            rq[ci + 2'd1] <= acc[67] ? -unit_rsp.result[31:0] : unit_rsp.result[31:0];
            ci <= (ci == 2'd2) ? 2'd0 : ci + 2'd1;
          end
          S_HAM: begin
            if (ci == 2'd3) begin
              q[0] <= qn[0];
              q[1] <= qn[1];
              q[2] <= qn[2];
              q[3] <= rsat(acc);
            end else begin
              qn[ci] <= rsat(acc);
            end
            ci <= ci + 2'd1;
          end
          S_DONE: begin
            out_data  <= '{orient_w: q[0], orient_x: q[1], orient_y: q[2], orient_z: q[3]};
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // the shared unit is never restarted mid-operation
  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    unit_req.start |-> !unit_rsp.busy) else $error("unit started while busy");
  // a finished operation is always awaited by the sequencer
  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    unit_rsp.done |-> wait_unit) else $error("unit result not awaited");
  // a reset request leaves the identity orientation
  a_reset_ident: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind) |=>
      (q[0] == ONE_Q30 && q[1] == '0 && q[2] == '0 && q[3] == '0))
    else $error("reset request did not restore identity");
`endif

endmodule

// ===== sim/virtual_trackball_rotation_unit_tb.sv =====
// Testbench for the virtual trackball rotation unit: directed and random drags, scoreboard check.
`timescale 1ns / 100ps

module virtual_trackball_rotation_unit_tb;
  import vtr_pkg::*;

  // Orientation tracker: follows every accepted request and keeps the
  // quaternions the block should return, oldest first.
  class orient_scoreboard;
    logic [15:0] radius;
    logic signed [31:0] quat [4];
    orient_t pending [$];
    int errors;
    int checked;

    function void clear_state();
      radius = RADIUS_RST;
      quat[0] = ONE_Q30;
      quat[1] = 0;
      quat[2] = 0;
      quat[3] = 0;
      pending.delete();
    endfunction

    // Integer square root, floor, of a 64-bit unsigned value.
    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Project a screen point onto the ball, or onto the hyperbolic sheet
    // once it lies past r/sqrt2. Coordinates come out in Q.30.
    function void project(logic signed [15:0] sx, logic signed [15:0] sy,
                          logic [63:0] r2, output longint pnt [3]);
      longint px;
      longint py;
      logic [63:0] d2;
      logic [63:0] dval;
      px = sx;
      py = sy;
      d2 = px * px + py * py;
      pnt[0] = px * 32768;
      pnt[1] = py * 32768;
      if (2 * d2 < r2) begin
        pnt[2] = root64((r2 - d2) << 30);
      end else begin
        dval = root64(d2 << 30);
        pnt[2] = (dval != 0) ? longint'((r2 << 30) / (2 * dval)) : 0;
      end
    endfunction

    // Round Q.60 to Q.30 and saturate to 32 bits.
    function logic signed [31:0] round_q30(longint s);
      longint v;
      v = (s + (64'sd1 <<< 29)) >>> 30;
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function void note_request(drag_req_t req);
      longint p1 [3];
      longint p2 [3];
      longint axis [3];
      longint rot [4];
      longint q [4];
      longint dv;
      logic [63:0] r;
      logic [63:0] norm;
      logic [63:0] len2;
      logic [63:0] t;
      orient_t o;
      r = radius;
      if (req.kind) begin
        quat[0] = ONE_Q30;
        quat[1] = 0;
        quat[2] = 0;
        quat[3] = 0;
      end else if (!(req.start_x == req.end_x && req.start_y == req.end_y)) begin
        project(req.start_x, req.start_y, r * r, p1);
        project(req.end_x, req.end_y, r * r, p2);
        axis[0] = (p1[1] * p2[2] - p1[2] * p2[1]) >>> 32;
        axis[1] = (p1[2] * p2[0] - p1[0] * p2[2]) >>> 32;
        axis[2] = (p1[0] * p2[1] - p1[1] * p2[0]) >>> 32;
        norm = root64(axis[0] * axis[0] + axis[1] * axis[1] + axis[2] * axis[2]);
        // collinear points or a sub-resolution axis: orientation stays put
        if (norm != 0) begin
          len2 = 0;
          for (int i = 0; i < 3; i++) begin
            dv = p1[i] - p2[i];
            len2 += dv * dv;
          end
          t = (r != 0) ? (root64(len2) << 15) / (2 * r) : 64'd1 << 30;
          if (t > (64'd1 << 30)) t = 64'd1 << 30;
          rot[0] = root64((64'd1 << 60) - t * t);
          for (int i = 0; i < 3; i++) rot[i + 1] = (axis[i] * longint'(t)) / longint'(norm);
          for (int i = 0; i < 4; i++) q[i] = quat[i];
          quat[0] = round_q30(rot[0] * q[0] - rot[1] * q[1] - rot[2] * q[2] - rot[3] * q[3]);
          quat[1] = round_q30(rot[0] * q[1] + rot[1] * q[0] + rot[2] * q[3] - rot[3] * q[2]);
          quat[2] = round_q30(rot[0] * q[2] - rot[1] * q[3] + rot[2] * q[0] + rot[3] * q[1]);
          quat[3] = round_q30(rot[0] * q[3] + rot[1] * q[2] - rot[2] * q[1] + rot[3] * q[0]);
        end
      end
      o.orient_w = quat[0];
      o.orient_x = quat[1];
      o.orient_y = quat[2];
      o.orient_z = quat[3];
      pending.push_back(o);
    endfunction

    function void check_result(orient_t got);
      orient_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.orient_w !== exp.orient_w)
        $display("%0t: orient_w exp %0d got %0d", $time, exp.orient_w, got.orient_w);
      if (got.orient_x !== exp.orient_x)
        $display("%0t: orient_x exp %0d got %0d", $time, exp.orient_x, got.orient_x);
      if (got.orient_y !== exp.orient_y)
        $display("%0t: orient_y exp %0d got %0d", $time, exp.orient_y, got.orient_y);
      if (got.orient_z !== exp.orient_z)
        $display("%0t: orient_z exp %0d got %0d", $time, exp.orient_z, got.orient_z);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  drag_req_t in_data;
  logic out_valid;
  logic out_ready;
  orient_t out_data;
  logic cfg_wen;
  logic [15:0] cfg_wdata;

  orient_scoreboard sb;
  int send_idle_pct;   // chance a request slot stays empty
  int recv_stall_pct;  // chance out_ready is low in a cycle
  int drags_sent;
  int resets_sent;

  virtual_trackball_rotation_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: randomly stalls out_ready, checks each accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hands one request to the block; idle gaps drop valid before the
  // request, then valid holds until the handshake. Valid stays up after
  // the handshake until the next request or a drain replaces it.
  task automatic send_request(drag_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    if (req.kind) resets_sent++; else drags_sent++;
    @(negedge clk);
  endtask

  task automatic send_drag(logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] ex, logic signed [15:0] ey);
    drag_req_t req;
    req.kind = 1'b0;
    req.start_x = sx;
    req.start_y = sy;
    req.end_x = ex;
    req.end_y = ey;
    send_request(req);
  endtask

  // Wait until every result is in, then let the block settle before a
  // radius write.
  task automatic drain_and_set_radius(logic [15:0] r);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wdata <= r;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.radius = r;
  endtask

  // Mostly small drags near the center; some anywhere, some equal points,
  // a few resets.
  task automatic random_request();
    drag_req_t req;
    int pick;
    pick = $urandom_range(99);
    req.start_x = 16'($urandom);
    req.start_y = 16'($urandom);
    req.end_x = 16'($urandom);
    req.end_y = 16'($urandom);
    req.kind = 1'b0;
    if (pick < 5) begin
      req.kind = 1'b1;
    end else if (pick < 10) begin
      req.end_x = req.start_x;
      req.end_y = req.start_y;
    end else if (pick < 70) begin
      req.start_x = $signed(16'($urandom_range(40000))) - 16'sd20000;
      req.start_y = $signed(16'($urandom_range(40000))) - 16'sd20000;
      req.end_x = req.start_x + $signed(16'($urandom_range(8000))) - 16'sd4000;
      req.end_y = req.start_y + $signed(16'($urandom_range(8000))) - 16'sd4000;
    end
    send_request(req);
  endtask

  initial begin
    logic [15:0] radii [5];
    sb = new();
    sb.clear_state();
    radii = '{16'd1, 16'd65535, 16'd16384, 16'd32768, RADIUS_RST};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: default radius, extremes, equal points, collinear, resets.
    send_drag(16'sd0, 16'sd0, 16'sd3000, 16'sd0);
    send_drag(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_drag(16'sd1000, 16'sd1000, 16'sd5000, 16'sd5000);
    send_drag(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_drag(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_drag(16'sd20000, 16'sd0, -16'sd20000, 16'sd1);
    send_drag(16'sd100, 16'sd200, 16'sd101, 16'sd200);
    send_drag(-16'sd32768, 16'sd0, 16'sd0, -16'sd32768);
    send_drag(16'sd30000, 16'sd30000, 16'sd30000, 16'sd30000);
    send_drag(16'sd0, 16'sd25000, 16'sd25000, 16'sd0);
    send_request('{kind: 1'b1, start_x: 16'sd5, start_y: 16'sd6, end_x: 16'sd7, end_y: 16'sd8});
    send_drag(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
    send_request('{kind: 1'b1, start_x: -16'sd1, start_y: -16'sd1, end_x: -16'sd1, end_y: -16'sd1});
    drain_and_set_radius(16'd1);
    send_drag(16'sd0, 16'sd0, 16'sd10, 16'sd20);
    send_drag(16'sd5000, -16'sd3000, -16'sd7000, 16'sd9000);
    drain_and_set_radius(16'd65535);
    send_drag(16'sd0, 16'sd0, 16'sd10, 16'sd20);
    send_drag(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_drag(16'sd12000, 16'sd4000, 16'sd11000, 16'sd6000);

    // Random phases through each idling mode and several radii.
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_set_radius(radii[ph]);
      for (int k = 0; k < 86; k++) begin
        case ((k / 20) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
          default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
        random_request();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d drags and %0d resets over five radius values, %0d results checked.",
             drags_sent, resets_sent, sb.checked);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Worst case: 448 requests plus stalls, 20 ns period.
  initial begin
    #50_000_000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vtr_pkg.sv
sv/vtr_mac.sv
sv/vtr_divsqrt.sv
sv/virtual_trackball_rotation_unit.sv
sim/virtual_trackball_rotation_unit_tb.sv
